// ----- hdl/cva_pkg.sv -----
// ============================================================================
// cva_pkg
// Shared types and constants of the channel voice allocator: item structs,
// request codes, controller states and the controller/datapath link.
// ============================================================================
package cva_pkg;

    // Sizes
    localparam int NUM_VOICES = 16;
    localparam int POOL_MAX   = 8;
    localparam int CH_W       = 8;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = 4;
    localparam int VIDX_W     = $clog2(NUM_VOICES);
    localparam int PIDX_W     = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;

    // Request codes
    localparam logic [1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CLEAR   = 2'd2;

    // Input item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] pool_entries;
        logic [3:0]  pool_len;
        logic [7:0]  release_channel;
    } t_req_item;

    // Result item
    typedef struct packed {
        logic [7:0] granted_channel;
        logic       from_idle;
    } t_rsp_item;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } t_ctl_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hdl/cva_ctrl.sv -----
// ============================================================================
// cva_ctrl
// Sequencer of the allocator: takes one item, runs the pool search, then
// commits the state update and the result once the result register is free.
// ============================================================================
module cva_ctrl import cva_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_SEARCH: begin
                o_cmd.search = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- hdl/cva_datapath.sv -----
// ============================================================================
// cva_datapath
// Busy flags, fallback counter with per-length residues, pool search and the
// result register of the allocator.
// ============================================================================
module cva_datapath import cva_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req_item i_in_item,
    input  t_dp_cmd   i_cmd,
    input  logic      i_out_stall,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    output t_rsp_item o_out_item
);

    // Held request
    t_req_item r_req;

    // Allocator state
    logic [NUM_VOICES-1:0] r_busy;
    logic [NUM_VOICES-1:0] n_busy;
    logic [CNT_W-1:0]      r_counter;
    logic [CNT_W-1:0]      n_counter;
    // r_res[k] holds the counter modulo k+1
    logic [PIDX_W-1:0]     r_res [POOL_MAX];
    logic [PIDX_W-1:0]     n_res [POOL_MAX];

    // Search results
    logic            r_hit;
    logic [CH_W-1:0] r_hit_ch;
    logic [CH_W-1:0] r_fb_ch;
    logic            r_empty;

    // Result register
    logic      r_out_valid;
    t_rsp_item n_out;
    t_rsp_item r_out;

    // Combinational search signals
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  len_m1;
    logic [PIDX_W-1:0] fb_idx;
    logic [CH_W-1:0]   pool_ch [POOL_MAX];
    logic [POOL_MAX-1:0] cand;
    logic              hit;
    logic [CH_W-1:0]   hit_ch;

    // Clamp the pool length and split the pool into entries
    always_comb begin
        if (r_req.pool_len > LEN_W'(POOL_MAX)) begin
            eff_len = LEN_W'(POOL_MAX);
        end else begin
            eff_len = r_req.pool_len;
        end
        len_m1 = eff_len - LEN_W'(1);
        // pick the entry at the counter modulo the pool length
        fb_idx = r_res[len_m1[PIDX_W-1:0]];
        for (int i = 0; i < POOL_MAX; i++) begin
            pool_ch[i] = r_req.pool_entries[CH_W*i +: CH_W];
        end
    end

    // Find the first listed idle voice in range
    always_comb begin
        hit    = 1'b0;
        hit_ch = '0;
        for (int i = 0; i < POOL_MAX; i++) begin
            cand[i] = (LEN_W'(i) < eff_len) && (pool_ch[i] < CH_W'(NUM_VOICES))
                      && !r_busy[pool_ch[i][VIDX_W-1:0]];
        end
        for (int i = POOL_MAX - 1; i >= 0; i--) begin
            if (cand[i]) begin
                hit    = 1'b1;
                hit_ch = pool_ch[i];
            end
        end
    end

    // Apply the request on commit
    always_comb begin
        n_busy    = r_busy;
        n_counter = r_counter;
        n_res     = r_res;
        n_out     = '0;
        if (i_cmd.commit) begin
            unique case (r_req.req_type)
                REQ_ACQUIRE: begin
                    if (!r_empty) begin
                        if (r_hit) begin
                            n_busy[r_hit_ch[VIDX_W-1:0]] = 1'b1;
                            n_out.granted_channel        = r_hit_ch;
                            n_out.from_idle              = 1'b1;
                        end else begin
                            n_out.granted_channel = r_fb_ch;
                            n_counter             = r_counter + CNT_W'(1);
                            // advance residues; the 32-bit wrap restarts them all
                            for (int k = 0; k < POOL_MAX; k++) begin
                                if (r_counter == '1) begin
                                    n_res[k] = '0;
                                end else if (r_res[k] == PIDX_W'(k)) begin
                                    n_res[k] = '0;
                                end else begin
                                    n_res[k] = r_res[k] + PIDX_W'(1);
                                end
                            end
                        end
                    end
                end
                REQ_RELEASE: begin
                    if (r_req.release_channel < CH_W'(NUM_VOICES)) begin
                        n_busy[r_req.release_channel[VIDX_W-1:0]] = 1'b0;
                    end
                end
                REQ_CLEAR: begin
                    n_busy = '0;
                end
                default: begin
                    n_out = '0;
                end
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_item;
        end
    end

    // Register the search outcome
    always_ff @(posedge i_clk) begin
        if (i_cmd.search) begin
            r_hit    <= hit;
            r_hit_ch <= hit_ch;
            r_fb_ch  <= pool_ch[fb_idx];
            r_empty  <= (eff_len == '0);
        end
    end

    // Allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_counter <= '0;
            for (int k = 0; k < POOL_MAX; k++) begin
                r_res[k] <= '0;
            end
        end else begin
            r_busy    <= n_busy;
            r_counter <= n_counter;
            r_res     <= n_res;
        end
    end

    // Result register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

// ----- hdl/channel_voice_allocator_top.sv -----
// The item is captured, its pool search is registered, and the commit loads the result register.
// The block takes one item at a time through accept, pool search and commit; the commit
// waits while the result register still holds an untaken result.
// The input is taken while a finished result waits in the result register.
// Reset (synchronous, active low) clears all busy flags, the fallback counter
// and the result valid; the block takes an item in the first cycle after reset.
// ============================================================================
// channel_voice_allocator_top
// Voice allocator with round-robin fallback: controller plus datapath.
// ============================================================================
module channel_voice_allocator_top import cva_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_req_item i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_rsp_item o_out_item
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    cva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // State and search logic
    cva_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- hdl/cva_checker.sv -----
// ============================================================================
// cva_checker
// Port-level checks of the channel voice allocator, bound to the top level.
// ============================================================================
module cva_checker import cva_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_req_item i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_rsp_item o_out_item
);

    // One item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

    // A new result only comes out of a busy cycle
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

    // An idle claim names a voice that exists
    a_idle_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.from_idle)
            |-> (o_out_item.granted_channel < CH_W'(NUM_VOICES)))
        else $error("idle grant out of range");

endmodule

bind channel_voice_allocator_top cva_checker u_cva_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- dv/channel_voice_allocator_top_tb.sv -----
// ============================================================================
// channel_voice_allocator_top_tb
// Self-checking bench for the voice allocator. The bench keeps its own copy of
// the busy flags and the round-robin counter and predicts each grant as its
// item is accepted. A directed burst hits the corner cases. Random traffic
// then runs through phases of sender gaps and receiver stalls. One phase also
// holds the output off long enough for the input to back up.
// ============================================================================
module channel_voice_allocator_top_tb;
    import cva_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         ITEMS_PER_PHASE = 200;
    localparam int         MAX_REPORTS  = 10;

    // DUT signals; the inputs are known from time zero
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_req_item i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_rsp_item o_out_item;

    // Stimulus and expectation stores
    t_req_item req_pending_q[$];
    t_rsp_item grant_expect_q[$];

    // Predicted allocator state
    logic [NUM_VOICES-1:0] busy_mask = '0;
    logic [CNT_W-1:0]      rr_next   = '0;

    // Traffic shaping
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_start     = 1'b0;
    int unsigned hold_left      = 0;

    int unsigned err_count = 0;

    channel_voice_allocator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Record one failure; only the first few are printed
    task automatic note_error(input string msg);
        if (err_count < MAX_REPORTS) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Append one item to the pending stimulus
    task automatic queue_req(input t_req_item r);
        req_pending_q.insert(req_pending_q.size(), r);
    endtask

    // Append one expected grant
    task automatic queue_grant(input t_rsp_item g);
        grant_expect_q.insert(grant_expect_q.size(), g);
    endtask

    // Work out the grant for one request and advance the predicted state
    function automatic t_rsp_item predict_grant(input t_req_item req);
        t_rsp_item       rsp;
        int unsigned     len;
        int unsigned     pick;
        int unsigned     k;
        logic [CH_W-1:0] ch;
        logic            claimed;
        rsp     = '0;
        claimed = 1'b0;
        case (req.req_type)
            REQ_ACQUIRE: begin
                len = (req.pool_len > POOL_MAX) ? POOL_MAX : req.pool_len;
                if (len != 0) begin
                    // first idle in-range entry wins
                    for (k = 0; k < len; k++) begin
                        ch = req.pool_entries[k*CH_W +: CH_W];
                        if (!claimed && ch < NUM_VOICES && !busy_mask[ch[VIDX_W-1:0]]) begin
                            busy_mask[ch[VIDX_W-1:0]] = 1'b1;
                            rsp.granted_channel = ch;
                            rsp.from_idle       = 1'b1;
                            claimed             = 1'b1;
                        end
                    end
                    // otherwise fall back to the round-robin pick
                    if (!claimed) begin
                        pick    = rr_next % len;
                        rr_next = rr_next + 1'b1;
                        rsp.granted_channel = req.pool_entries[pick*CH_W +: CH_W];
                    end
                end
            end
            REQ_RELEASE: begin
                if (req.release_channel < NUM_VOICES) begin
                    busy_mask[req.release_channel[VIDX_W-1:0]] = 1'b0;
                end
            end
            REQ_CLEAR: begin
                busy_mask = '0;
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function automatic t_req_item make_req(input logic [1:0] kind, input logic [63:0] pool,
                                           input logic [3:0] len, input logic [7:0] rel);
        t_req_item r;
        r.req_type        = kind;
        r.pool_entries    = pool;
        r.pool_len        = len;
        r.release_channel = rel;
        return r;
    endfunction

    // Mostly in-range pools and channels, with some wild bytes and lengths
    function automatic t_req_item random_req();
        t_req_item   r;
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(99);
        if (sel < 60) begin
            r.req_type = REQ_ACQUIRE;
        end else if (sel < 88) begin
            r.req_type = REQ_RELEASE;
        end else if (sel < 95) begin
            r.req_type = REQ_CLEAR;
        end else begin
            r.req_type = REQ_UNKNOWN;
        end
        for (k = 0; k < POOL_MAX; k++) begin
            if ($urandom_range(9) == 0) begin
                r.pool_entries[k*CH_W +: CH_W] = CH_W'($urandom_range(255));
            end else begin
                r.pool_entries[k*CH_W +: CH_W] = CH_W'($urandom_range(NUM_VOICES-1));
            end
        end
        sel = $urandom_range(19);
        if (sel == 0) begin
            r.pool_len = '0;
        end else if (sel == 1) begin
            r.pool_len = LEN_W'($urandom_range(15, POOL_MAX+1));
        end else begin
            r.pool_len = LEN_W'($urandom_range(POOL_MAX, 1));
        end
        if ($urandom_range(9) == 0) begin
            r.release_channel = CH_W'($urandom_range(255));
        end else begin
            r.release_channel = CH_W'($urandom_range(NUM_VOICES-1));
        end
        return r;
    endfunction

    // Driver: predict on accept, then offer the next pending item or go idle
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            queue_grant(predict_grant(i_in_item));
        end
        if (!i_in_valid || !o_in_stall) begin
            if (i_rst_n && req_pending_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= req_pending_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted down here
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_rsp_item exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grant_expect_q.size() == 0) begin
                note_error($sformatf("unexpected result ch=%0d idle=%0b",
                                     o_out_item.granted_channel, o_out_item.from_idle));
            end else begin
                exp_rsp = grant_expect_q.pop_front();
                if (exp_rsp.granted_channel != o_out_item.granted_channel ||
                    exp_rsp.from_idle != o_out_item.from_idle) begin
                    note_error($sformatf("expected ch=%0d idle=%0b, got ch=%0d idle=%0b",
                                         exp_rsp.granted_channel, exp_rsp.from_idle,
                                         o_out_item.granted_channel, o_out_item.from_idle));
                end
            end
        end
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // Wait until every queued item is taken and every grant has come back
    task automatic wait_drained();
        while (req_pending_q.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        while (grant_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (ITEMS_PER_PHASE) queue_req(random_req());
        wait_drained();
    endtask

    // Stimulus sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner cases, no idling
        queue_req(make_req(REQ_ACQUIRE, 64'h03, 4'd1, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h03, 4'd1, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, '1, 4'd0, 8'hFF));
        queue_req(make_req(REQ_ACQUIRE, '1, 4'd15, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0000_0000_0005_C810, 4'd8, 8'd0));
        queue_req(make_req(REQ_RELEASE, 64'h0, 4'd0, 8'd3));
        queue_req(make_req(REQ_RELEASE, '1, 4'd15, 8'd255));
        queue_req(make_req(REQ_RELEASE, 64'h0, 4'd0, 8'd16));
        queue_req(make_req(REQ_RELEASE, 64'h0, 4'd0, 8'd15));
        queue_req(make_req(REQ_UNKNOWN, 64'h0706_0504_0302_0100, 4'd8, 8'd5));
        queue_req(make_req(REQ_ACQUIRE, 64'h0706_0504_0302_0100, 4'd8, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0000_0000_0000_000F, 4'd8, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0F0F_0F0F_0F0F_0F0F, 4'd8, 8'd0));
        queue_req(make_req(REQ_CLEAR, '1, 4'd15, 8'hFF));
        queue_req(make_req(REQ_ACQUIRE, '1, 4'd8, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0706_0504_0302_0100, 4'd9, 8'd0));
        queue_req(make_req(REQ_ACQUIRE, 64'h0706_0504_0302_0100, 4'd15, 8'd0));
        wait_drained();

        // hold the output off while the sender keeps offering
        hold_start <= 1'b1;
        @(negedge i_clk);
        hold_start <= 1'b0;
        repeat (40) queue_req(random_req());
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(75, 0);
        run_random_phase(0, 75);
        run_random_phase(16, 16);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
